// ===== hdl/flrsc_pkg.sv =====
// flrsc_pkg: types and constants for the fan/light remote state codec.
// No dependencies; used by the channel interfaces and every module.
package flrsc_pkg;

    // Request operation codes
    typedef enum logic [3:0] {
        OP_FRAME   = 4'd0,
        OP_LIGHT   = 4'd1,
        OP_BRIGHT  = 4'd2,
        OP_KELVIN  = 4'd3,
        OP_FAN     = 4'd4,
        OP_SPEED   = 4'd5,
        OP_REVERSE = 4'd6,
        OP_MODE    = 4'd7,
        OP_RESEND  = 4'd8
    } op_t;

    // Dense button numbering of the transmit frame
    typedef enum logic [3:0] {
        BTN_LIGHT_PWR = 4'd0,
        BTN_BR_UP     = 4'd1,
        BTN_BR_DN     = 4'd2,
        BTN_K_UP      = 4'd3,
        BTN_K_DN      = 4'd4,
        BTN_FAN_PWR   = 4'd5,
        BTN_SP_UP     = 4'd6,
        BTN_SP_DN     = 4'd7,
        BTN_REVERSE   = 4'd8,
        BTN_MODE      = 4'd9
    } btn_t;

    // Fan mode codes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_NIGHT  = 2'd1;
    localparam logic [1:0] MODE_BREEZE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_REPEAT_COUNT   = 2'd1;
    localparam logic [1:0] CFG_LINK_PRESENT   = 2'd2;
    localparam int         CFG_DATA_W         = 16;

    // Value limits
    localparam logic [3:0] BR_MIN     = 4'd2;
    localparam logic [3:0] BR_MAX     = 4'd11;
    localparam logic [4:0] KELVIN_MIN = 5'd4;
    localparam logic [4:0] KELVIN_MAX = 5'd24;
    localparam logic [2:0] SPEED_MAX  = 3'd6;
    localparam logic [2:0] FST_OFF    = 3'd0;
    localparam logic [2:0] FST_BREEZE = 3'd7;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] frame_flags;
        logic [7:0] frame_light_fan;
        logic [7:0] set_value;
    } req_t;

    typedef struct packed {
        logic       frame_sent;
        logic [7:0] tx_flags;
        logic [7:0] tx_light_fan;
        logic [3:0] tx_button;
        logic       light_on;
        logic [3:0] brightness_step;
        logic [4:0] kelvin_index;
        logic       fan_running;
        logic [2:0] speed_level;
        logic [1:0] mode_code;
        logic       direction_reversed;
    } rsp_t;

    typedef struct packed {
        logic       light_on;
        logic [3:0] brightness;
        logic [4:0] kelvin;
        logic       fan_on;
        logic [2:0] speed;
        logic [1:0] mode;
        logic       reverse;
    } state_t;

endpackage

// ===== hdl/flrsc_req_if.sv =====
// flrsc_req_if: valid/ready channel carrying one request item.
// Depends on flrsc_pkg.
interface flrsc_req_if;
    logic              valid;
    logic              ready;
    flrsc_pkg::req_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/flrsc_rsp_if.sv =====
// flrsc_rsp_if: valid/ready channel carrying one result item.
// Depends on flrsc_pkg.
interface flrsc_rsp_if;
    logic              valid;
    logic              ready;
    flrsc_pkg::rsp_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/flrsc_step.sv =====
// flrsc_step: combinational state update and frame encode for one request.
// Depends on flrsc_pkg.
module flrsc_step (
    input  flrsc_pkg::req_t   req,
    input  flrsc_pkg::state_t state,
    input  logic              link_present,
    output flrsc_pkg::state_t state_next,
    output flrsc_pkg::rsp_t   rsp
);

    logic             on;
    logic             send;
    logic [3:0]       btn;
    logic [4:0]       ki;
    logic [3:0]       br;
    logic [2:0]       fst;
    logic [3:0]       bv;
    logic [4:0]       kv;
    logic [2:0]       sv;
    logic [1:0]       mv;
    logic [2:0]       tx_fst;
    logic [3:0]       tx_br;
    flrsc_pkg::state_t s;

    always_comb
    begin
        on  = (req.set_value != 8'd0);
        ki  = req.frame_flags[4:0];
        br  = req.frame_light_fan[3:0];
        fst = req.frame_light_fan[6:4];

        // setter clamps
        if (req.set_value < {4'd0, flrsc_pkg::BR_MIN})
            bv = flrsc_pkg::BR_MIN;
        else if (req.set_value > {4'd0, flrsc_pkg::BR_MAX})
            bv = flrsc_pkg::BR_MAX;
        else
            bv = req.set_value[3:0];

        if (req.set_value < {3'd0, flrsc_pkg::KELVIN_MIN})
            kv = flrsc_pkg::KELVIN_MIN;
        else if (req.set_value > {3'd0, flrsc_pkg::KELVIN_MAX})
            kv = flrsc_pkg::KELVIN_MAX;
        else
            kv = req.set_value[4:0];

        sv = (req.set_value > {5'd0, flrsc_pkg::SPEED_MAX}) ? flrsc_pkg::SPEED_MAX
                                                           : req.set_value[2:0];
        mv = (req.set_value > {6'd0, flrsc_pkg::MODE_BREEZE}) ? flrsc_pkg::MODE_BREEZE
                                                             : req.set_value[1:0];

        s    = state;
        send = 1'b0;
        btn  = flrsc_pkg::BTN_LIGHT_PWR;

        case (req.op)
            flrsc_pkg::OP_FRAME:
            begin
                s.reverse = req.frame_flags[5];
                if (req.frame_flags[7])
                    s.mode = flrsc_pkg::MODE_BREEZE;
                else if (req.frame_flags[6])
                    s.mode = flrsc_pkg::MODE_NIGHT;
                else
                    s.mode = flrsc_pkg::MODE_NORMAL;
                if (ki >= flrsc_pkg::KELVIN_MIN && ki <= flrsc_pkg::KELVIN_MAX)
                    s.kelvin = ki;
                if (br >= flrsc_pkg::BR_MIN && br <= flrsc_pkg::BR_MAX)
                    s.brightness = br;
                s.light_on = req.frame_light_fan[7];
                if (fst == flrsc_pkg::FST_OFF)
                    s.fan_on = 1'b0;
                else if (fst == flrsc_pkg::FST_BREEZE)
                begin
                    s.fan_on = 1'b1;
                    s.mode   = flrsc_pkg::MODE_BREEZE;
                end
                else
                begin
                    s.fan_on = 1'b1;
                    s.speed  = fst;
                end
            end
            flrsc_pkg::OP_LIGHT:
            begin
                if (state.light_on != on)
                begin
                    s.light_on = on;
                    send       = 1'b1;
                    btn        = flrsc_pkg::BTN_LIGHT_PWR;
                end
            end
            flrsc_pkg::OP_BRIGHT:
            begin
                if (!(bv == state.brightness && state.light_on))
                begin
                    s.brightness = bv;
                    s.light_on   = 1'b1;
                    send         = 1'b1;
                    btn          = (bv >= state.brightness) ? flrsc_pkg::BTN_BR_UP
                                                            : flrsc_pkg::BTN_BR_DN;
                end
            end
            flrsc_pkg::OP_KELVIN:
            begin
                if (!(kv == state.kelvin && state.light_on))
                begin
                    s.kelvin   = kv;
                    s.light_on = 1'b1;
                    send       = 1'b1;
                    btn        = (kv >= state.kelvin) ? flrsc_pkg::BTN_K_UP
                                                      : flrsc_pkg::BTN_K_DN;
                end
            end
            flrsc_pkg::OP_FAN:
            begin
                if (state.fan_on != on)
                begin
                    s.fan_on = on;
                    send     = 1'b1;
                    btn      = flrsc_pkg::BTN_FAN_PWR;
                end
            end
            flrsc_pkg::OP_SPEED:
            begin
                if (sv == 3'd0)
                begin
                    // speed zero switches the fan off
                    if (state.fan_on)
                    begin
                        s.fan_on = 1'b0;
                        send     = 1'b1;
                        btn      = flrsc_pkg::BTN_FAN_PWR;
                    end
                end
                else if (!(state.fan_on && sv == state.speed
                           && state.mode == flrsc_pkg::MODE_NORMAL))
                begin
                    s.speed  = sv;
                    s.fan_on = 1'b1;
                    s.mode   = flrsc_pkg::MODE_NORMAL;
                    send     = 1'b1;
                    btn      = (sv >= state.speed) ? flrsc_pkg::BTN_SP_UP
                                                   : flrsc_pkg::BTN_SP_DN;
                end
            end
            flrsc_pkg::OP_REVERSE:
            begin
                if (state.reverse != on)
                begin
                    s.reverse = on;
                    send      = 1'b1;
                    btn       = flrsc_pkg::BTN_REVERSE;
                end
            end
            flrsc_pkg::OP_MODE:
            begin
                if (state.mode != mv)
                begin
                    s.mode = mv;
                    if (mv != flrsc_pkg::MODE_NORMAL)
                        s.fan_on = 1'b1;
                    if (mv == flrsc_pkg::MODE_NIGHT)
                        s.speed = 3'd1;
                    send = 1'b1;
                    btn  = flrsc_pkg::BTN_MODE;
                end
            end
            flrsc_pkg::OP_RESEND:
            begin
                send = 1'b1;
                btn  = flrsc_pkg::BTN_FAN_PWR;
            end
            default:
            begin
                // unused op codes: no change, no frame
            end
        endcase

        send = send & link_present;

        // frame encode from the updated state
        if (!s.fan_on)
            tx_fst = flrsc_pkg::FST_OFF;
        else if (s.mode == flrsc_pkg::MODE_BREEZE)
            tx_fst = flrsc_pkg::FST_BREEZE;
        else
            tx_fst = s.speed;

        if (s.brightness < flrsc_pkg::BR_MIN)
            tx_br = flrsc_pkg::BR_MIN;
        else if (s.brightness > flrsc_pkg::BR_MAX)
            tx_br = flrsc_pkg::BR_MAX;
        else
            tx_br = s.brightness;

        state_next             = s;
        rsp.frame_sent         = send;
        rsp.tx_flags           = send ? {s.mode == flrsc_pkg::MODE_BREEZE,
                                         s.mode == flrsc_pkg::MODE_NIGHT,
                                         s.reverse, s.kelvin} : 8'd0;
        rsp.tx_light_fan       = send ? {s.light_on, tx_fst, tx_br} : 8'd0;
        rsp.tx_button          = send ? btn : 4'd0;
        rsp.light_on           = s.light_on;
        rsp.brightness_step    = s.brightness;
        rsp.kelvin_index       = s.kelvin;
        rsp.fan_running        = s.fan_on;
        rsp.speed_level        = s.speed;
        rsp.mode_code          = s.mode;
        rsp.direction_reversed = s.reverse;
    end

endmodule

// ===== hdl/fan_light_remote_state_codec.sv =====
// fan_light_remote_state_codec: top level of the fan/light state mirror and codec.
// Depends on flrsc_pkg, flrsc_req_if, flrsc_rsp_if and flrsc_step.
//
// Usage:
//   req  - request channel (valid/ready). op selects received-frame decode,
//          one of the setters, or resend. One request gives exactly one result.
//   rsp  - result channel (valid/ready). Each result carries the transmit
//          frame (frame_sent, tx_flags, tx_light_fan, tx_button; all zero when
//          nothing is sent) and the full fan/light state after the request.
//   cfg  - write-only register port (cfg_we, cfg_index, cfg_data). Only
//          link_present affects this block; device address and repeat count
//          belong to the downstream transmitter and are accepted and dropped.
// Throughput: one request per cycle while req.ready is high. The state update and
//   frame encode are a single combinational pass from the state registers into the
//   result register, or into the skid register while the output stalls.
// Stall: a two-deep output (result register plus skid register) keeps req.ready
//   high while one result waits; req.ready drops only when both are full.
// Reset: state clears to zero, link_present comes up as 1, output empty.
module fan_light_remote_state_codec (
    input  logic                                 clk,
    input  logic                                 rst_n,
    flrsc_req_if.sink                            req,
    flrsc_rsp_if.source                          rsp,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [flrsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    flrsc_pkg::state_t state_reg;
    flrsc_pkg::state_t state_next;
    logic              link_present_reg;

    flrsc_pkg::rsp_t   step_rsp;
    flrsc_pkg::rsp_t   out_data_reg;
    flrsc_pkg::rsp_t   skid_data_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    logic              accept;
    logic              pop;

    assign req.ready   = !skid_valid_reg;
    assign accept      = req.valid && !skid_valid_reg;
    assign pop         = out_valid_reg && rsp.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    flrsc_step u_step (
        .req          (req.payload),
        .state        (state_reg),
        .link_present (link_present_reg),
        .state_next   (state_next),
        .rsp          (step_rsp)
    );

    // config: only the link flag is kept here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            link_present_reg <= 1'b1;
        else if (cfg_we)
        begin
            case (cfg_index)
                flrsc_pkg::CFG_LINK_PRESENT: link_present_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // mirrored state advances on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    // output register + skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= step_rsp;
            else
                out_data_reg <= step_rsp;
        end
    end

endmodule
